// File: design/etuc_pkg.sv
// Shared types and constants for the epoch-to-UTC calendar converter.
// No dependencies; imported by etuc_ctrl, etuc_dp and the top level.
package etuc_pkg;

  localparam int unsigned EPOCH_W = 32;
  localparam int unsigned DAYS_W  = 16;
  localparam int unsigned YEAR_W  = 12;
  localparam int unsigned REM_W   = 6;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [6:0]        EPOCH_MOD100   = 7'd70;
  localparam logic [8:0]        EPOCH_MOD400   = 9'd370;
  localparam logic [DAYS_W-1:0] DAYS_COMMON    = 16'd365;
  localparam logic [DAYS_W-1:0] DAYS_LEAP      = 16'd366;
  localparam logic [DAYS_W-1:0] EPOCH_WEEKDAY  = 16'd4;
  localparam logic [3:0]        MONTH_DEC      = 4'd11;
  localparam logic [3:0]        MONTH_FEB      = 4'd1;

  // constant divisors
  localparam logic [REM_W-1:0] DIV_60 = 6'd60;
  localparam logic [REM_W-1:0] DIV_24 = 6'd24;
  localparam logic [REM_W-1:0] DIV_7  = 6'd7;

  // reciprocals: quotient is (n * RECIP) >> SHIFT, exact over each dividend range
  localparam logic [EPOCH_W-1:0] RECIP_60 = 32'h8888_8889;  // any 32-bit n
  localparam logic [EPOCH_W-1:0] RECIP_24 = 32'hAAAA_AAAB;  // any 32-bit n
  localparam logic [EPOCH_W-1:0] RECIP_7  = 32'h0001_2493;  // n below 104857
  localparam int unsigned        SHIFT_60 = 37;
  localparam int unsigned        SHIFT_24 = 36;
  localparam int unsigned        SHIFT_7  = 19;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEC,
    S_MIN,
    S_HR,
    S_WD,
    S_YEAR,
    S_MONTH,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_SEC,
    SEL_MIN,
    SEL_HR,
    SEL_WD
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_step;
    div_sel_t div_sel;
    logic     year_step;
    logic     month_step;
    logic     publish;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic year_fit;
    logic month_fit;
  } status_t;

  function automatic logic [DAYS_W-1:0] month_len(input logic [3:0] m, input logic leap);
    logic [DAYS_W-1:0] len;
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 16'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                  len = 16'd30;
      MONTH_FEB:                                len = leap ? 16'd29 : 16'd28;
      default:                                  len = 16'd31;
    endcase
    return len;
  endfunction

endpackage

// File: design/etuc_ctrl.sv
// Sequencer for the calendar converter: steps the divider passes, the year
// and month searches, and owns the input and output handshakes. Uses etuc_pkg.
module etuc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  etuc_pkg::status_t status,
  output etuc_pkg::cmd_t    cmd
);
  import etuc_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept;
  logic   publish;

  assign accept  = in_valid && (state == S_IDLE);
  assign publish = (state == S_DONE) && (!out_valid || !out_stall);
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_SEC;
      S_SEC:   if (status.div_last) state_next = S_MIN;
      S_MIN:   if (status.div_last) state_next = S_HR;
      S_HR:    if (status.div_last) state_next = S_WD;
      S_WD:    if (status.div_last) state_next = S_YEAR;
      S_YEAR:  if (status.year_fit) state_next = S_MONTH;
      S_MONTH: if (status.month_fit) state_next = S_DONE;
      S_DONE:  if (publish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_sel = SEL_SEC;
    case (state)
      S_IDLE:  cmd.load = accept;
      S_SEC: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = SEL_SEC;
      end
      S_MIN: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = SEL_MIN;
      end
      S_HR: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = SEL_HR;
      end
      S_WD: begin
        cmd.div_step = 1'b1;
        cmd.div_sel  = SEL_WD;
      end
      S_YEAR:  cmd.year_step  = 1'b1;
      S_MONTH: cmd.month_step = 1'b1;
      S_DONE:  cmd.publish    = publish;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (publish) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_publish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    publish |=> out_valid)
    else $error("result not presented after publish");

  a_held_result_kept: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && !publish) |=> out_valid)
    else $error("stalled result dropped");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && out_stall) |=> (state == S_DONE))
    else $error("left done state while output slot busy");

endmodule

// File: design/etuc_dp.sv
// Datapath of the calendar converter: reciprocal constant divider, year and
// month subtract loops, result registers. Uses etuc_pkg; driven by etuc_ctrl.
module etuc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  etuc_pkg::cmd_t                    cmd,
  output etuc_pkg::status_t                 status,
  input  logic [etuc_pkg::EPOCH_W-1:0]      epoch_seconds,
  output logic [etuc_pkg::YEAR_W-1:0]       year,
  output logic [3:0]                        month,
  output logic [4:0]                        day_of_month,
  output logic [4:0]                        hour,
  output logic [5:0]                        minute,
  output logic [5:0]                        second,
  output logic [2:0]                        weekday
);
  import etuc_pkg::*;

  // divider: quotient step, then remainder step
  logic [EPOCH_W-1:0]   n;
  logic [EPOCH_W-1:0]   q;
  logic                 phase;
  logic [REM_W-1:0]     divisor;
  logic [EPOCH_W-1:0]   recip;
  logic [2*EPOCH_W-1:0] prod;
  logic [EPOCH_W-1:0]   q_calc;
  logic [2*REM_W-1:0]   qd;
  logic [REM_W-1:0]     r_calc;

  // calendar search
  logic [DAYS_W-1:0]  day_cnt;
  logic [YEAR_W-1:0]  y;
  logic [6:0]         ymod100;
  logic [8:0]         ymod400;
  logic [3:0]         m;
  logic               leap;
  logic [DAYS_W-1:0]  ylen;
  logic [DAYS_W-1:0]  mlen;

  // partial results
  logic [5:0] sec_w;
  logic [5:0] min_w;
  logic [4:0] hr_w;
  logic [2:0] wd_w;

  always_comb begin
    case (cmd.div_sel)
      SEL_SEC: begin
        divisor = DIV_60;
        recip   = RECIP_60;
      end
      SEL_MIN: begin
        divisor = DIV_60;
        recip   = RECIP_60;
      end
      SEL_HR: begin
        divisor = DIV_24;
        recip   = RECIP_24;
      end
      SEL_WD: begin
        divisor = DIV_7;
        recip   = RECIP_7;
      end
      default: begin
        divisor = DIV_60;
        recip   = RECIP_60;
      end
    endcase
  end

  assign prod = {{EPOCH_W{1'b0}}, n} * {{EPOCH_W{1'b0}}, recip};

  always_comb begin
    case (cmd.div_sel)
      SEL_SEC: q_calc = EPOCH_W'(prod >> SHIFT_60);
      SEL_MIN: q_calc = EPOCH_W'(prod >> SHIFT_60);
      SEL_HR:  q_calc = EPOCH_W'(prod >> SHIFT_24);
      SEL_WD:  q_calc = EPOCH_W'(prod >> SHIFT_7);
      default: q_calc = EPOCH_W'(prod >> SHIFT_60);
    endcase
  end

  // remainder is below 64, so the low bits suffice
  assign qd     = {{REM_W{1'b0}}, q[REM_W-1:0]} * {{REM_W{1'b0}}, divisor};
  assign r_calc = n[REM_W-1:0] - qd[REM_W-1:0];

  assign leap = ((y[1:0] == 2'b00) && (ymod100 != 7'd0)) || (ymod400 == 9'd0);
  assign ylen = leap ? DAYS_LEAP : DAYS_COMMON;
  assign mlen = month_len(m, leap);

  assign status.div_last  = phase;
  assign status.year_fit  = (day_cnt < ylen);
  assign status.month_fit = (m == MONTH_DEC) || (day_cnt < mlen);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n       <= epoch_seconds;
      phase   <= 1'b0;
      y       <= EPOCH_YEAR;
      ymod100 <= EPOCH_MOD100;
      ymod400 <= EPOCH_MOD400;
      m       <= '0;
    end else if (cmd.div_step) begin
      if (!phase) begin
        q     <= q_calc;
        phase <= 1'b1;
      end else begin
        phase <= 1'b0;
        case (cmd.div_sel)
          SEL_SEC: begin
            sec_w <= r_calc;
            n     <= q;
          end
          SEL_MIN: begin
            min_w <= r_calc;
            n     <= q;
          end
          SEL_HR: begin
            hr_w    <= r_calc[4:0];
            day_cnt <= q[DAYS_W-1:0];
            n       <= {{(EPOCH_W-DAYS_W){1'b0}}, q[DAYS_W-1:0] + EPOCH_WEEKDAY};
          end
          SEL_WD: begin
            wd_w <= r_calc[2:0];
          end
          default: begin
            n <= q;
          end
        endcase
      end
    end else if (cmd.year_step) begin
      if (!status.year_fit) begin
        day_cnt <= day_cnt - ylen;
        y       <= y + 1'b1;
        ymod100 <= (ymod100 == 7'd99)  ? 7'd0 : ymod100 + 1'b1;
        ymod400 <= (ymod400 == 9'd399) ? 9'd0 : ymod400 + 1'b1;
      end
    end else if (cmd.month_step) begin
      if (!status.month_fit) begin
        day_cnt <= day_cnt - mlen;
        m       <= m + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      year         <= y;
      month        <= m;
      day_of_month <= day_cnt[4:0] + 5'd1;
      hour         <= hr_w;
      minute       <= min_w;
      second       <= sec_w;
      weekday      <= wd_w;
    end
  end

  a_remainder_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && phase) |-> (r_calc < divisor))
    else $error("divider remainder out of range");

  a_year_advance: assert property (@(posedge clk) disable iff (rst)
    (cmd.year_step && !status.year_fit) |=> (y == $past(y) + 1'b1))
    else $error("year counter did not advance");

  a_month_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.month_step |-> (m <= MONTH_DEC))
    else $error("month search ran past December");

  a_result_fields: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> (day_of_month != 5'd0 && weekday != 3'd7 && hour < 5'd24))
    else $error("calendar field out of range");

endmodule

// File: design/epoch_to_utc_calendar_top.sv
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 UTC into the
// UTC year, month (0 = January), day of month, hour, minute, second and
// weekday (0 = Sunday). One item is worked on at a time: after acceptance
// it does the divisions by 60, 60 and 24 and the weekday modulo 7 (a
// reciprocal multiply, then a remainder step, for each), one step per year
// from 1970 up to and including the result year, one per month up to and
// including the result month, and then loads the output register. A
// finished result sits in an output register, so the next item is taken
// while it still waits to be read; a new result is held back only while the
// previous one is still unread.
// Depends on etuc_pkg, etuc_ctrl, etuc_dp.
module epoch_to_utc_calendar_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [etuc_pkg::EPOCH_W-1:0] epoch_seconds,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [etuc_pkg::YEAR_W-1:0]  year,
  output logic [3:0]                   month,
  output logic [4:0]                   day_of_month,
  output logic [4:0]                   hour,
  output logic [5:0]                   minute,
  output logic [5:0]                   second,
  output logic [2:0]                   weekday
);
  import etuc_pkg::*;

  cmd_t    cmd;
  status_t status;

  etuc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  etuc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .epoch_seconds (epoch_seconds),
    .year          (year),
    .month         (month),
    .day_of_month  (day_of_month),
    .hour          (hour),
    .minute        (minute),
    .second        (second),
    .weekday       (weekday)
  );

endmodule

// File: sim/epoch_to_utc_calendar_top_test.sv
// Testbench for epoch_to_utc_calendar_top: drives epoch second counts and checks each
// calendar result against a built-in date predictor, under random gaps and output stalls.
// Depends on etuc_pkg and the design files of epoch_to_utc_calendar_top.
`timescale 1ns / 1ps

module epoch_to_utc_calendar_top_test;

  import etuc_pkg::*;

  typedef struct {
    logic [EPOCH_W-1:0] epoch;
    logic [YEAR_W-1:0]  year;
    logic [3:0]         month;
    logic [4:0]         day_of_month;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [2:0]         weekday;
  } utc_date_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [EPOCH_W-1:0] epoch_seconds;
  logic               out_valid;
  logic               out_stall;
  logic [YEAR_W-1:0]  year;
  logic [3:0]         month;
  logic [4:0]         day_of_month;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [5:0]         second;
  logic [2:0]         weekday;

  utc_date_t   pending_dates[$];
  int unsigned mismatch_count;
  int unsigned burst_left;

  epoch_to_utc_calendar_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .epoch_seconds(epoch_seconds),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .weekday      (weekday)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit is_leap_year(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic utc_date_t calendar_of(input logic [EPOCH_W-1:0] t);
    int unsigned month_lengths[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    utc_date_t   d;
    int unsigned rest;
    int unsigned days;
    int unsigned y;
    logic [3:0]  m;
    int unsigned len;
    d.epoch  = t;
    rest     = t;
    d.second = 6'(rest % 60);
    rest     = rest / 60;
    d.minute = 6'(rest % 60);
    rest     = rest / 60;
    d.hour   = 5'(rest % 24);
    days     = rest / 24;
    d.weekday = 3'((days + 4) % 7);
    y = 1970;
    forever begin
      len = is_leap_year(y) ? 366 : 365;
      if (days < len) break;
      days -= len;
      y++;
    end
    m = 4'd0;
    while (m < 11) begin
      len = (m == 1 && is_leap_year(y)) ? 29 : month_lengths[m];
      if (days < len) break;
      days -= len;
      m++;
    end
    d.year         = 12'(y);
    d.month        = m;
    d.day_of_month = 5'(days + 1);
    return d;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [EPOCH_W-1:0] epoch,
                             input int unsigned want, input int unsigned got);
    if (want != got)
      report_mismatch($sformatf("epoch %0d %s expected %0d got %0d", epoch, name, want, got));
  endtask

  // one item; entered and left at a falling edge
  task automatic send_epoch(input logic [EPOCH_W-1:0] t);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid      <= 1'b1;
    epoch_seconds <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_dates.push_back(calendar_of(t));
    burst_left--;
    @(negedge clk);
  endtask

  task automatic test_directed_instants();
    logic [EPOCH_W-1:0] picks[$];
    picks = '{32'd0, 32'hFFFF_FFFF, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399,
              32'd86400, 32'd31535999, 32'd31536000, 32'd68169600, 32'd68256000,
              32'd951782400, 32'd951868800, 32'd978307199, 32'd4107456000,
              32'd4107542400, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5555_5555,
              32'hAAAA_AAAA, 32'd4102444799, 32'd4102444800};
    foreach (picks[i]) send_epoch(picks[i]);
  endtask

  task automatic test_uniform_instants();
    repeat (1000) send_epoch($urandom);
  endtask

  // instants a few seconds either side of midnight, so year and month roll-overs are hit
  task automatic test_midnight_instants();
    longint unsigned t;
    repeat (700) begin
      t = longint'($urandom_range(0, 49710)) * 86400;
      if ($urandom_range(0, 1) == 0) t += $urandom_range(0, 2);
      else t += 86400 - $urandom_range(1, 3);
      if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF - $urandom_range(0, 3);
      send_epoch(t[EPOCH_W-1:0]);
    end
  endtask

  task automatic test_narrow_instants();
    int unsigned w;
    repeat (200) begin
      w = $urandom_range(1, 31);
      send_epoch($urandom & ((32'd1 << w) - 1));
    end
  endtask

  always @(posedge clk) begin
    utc_date_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        report_mismatch($sformatf("result with no item outstanding, year %0d", year));
      end else begin
        want = pending_dates.pop_front();
        check_field("year", want.epoch, 32'(want.year), 32'(year));
        check_field("month", want.epoch, 32'(want.month), 32'(month));
        check_field("day_of_month", want.epoch, 32'(want.day_of_month), 32'(day_of_month));
        check_field("hour", want.epoch, 32'(want.hour), 32'(hour));
        check_field("minute", want.epoch, 32'(want.minute), 32'(minute));
        check_field("second", want.epoch, 32'(want.second), 32'(second));
        check_field("weekday", want.epoch, 32'(want.weekday), 32'(weekday));
      end
    end
  end

  // receiver stall pattern: phases of no stall, light, heavy and long stalls
  initial begin
    int unsigned phase_len;
    int unsigned mode;
    int unsigned hold;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      mode      = $urandom_range(0, 3);
      phase_len = $urandom_range(100, 800);
      while (phase_len > 0) begin
        case (mode)
          0: begin
            out_stall <= 1'b0;
            hold = 1;
          end
          1: begin
            out_stall <= ($urandom_range(0, 3) == 0);
            hold = 1;
          end
          2: begin
            out_stall <= ($urandom_range(0, 9) < 7);
            hold = 1;
          end
          default: begin
            out_stall <= ~out_stall;
            hold = $urandom_range(1, 25);
          end
        endcase
        repeat (hold) @(negedge clk);
        phase_len = (phase_len > hold) ? phase_len - hold : 0;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    epoch_seconds  = '0;
    mismatch_count = 0;
    burst_left     = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_instants();
    test_uniform_instants();
    test_midnight_instants();
    test_narrow_instants();

    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    if (mismatch_count == 0 && pending_dates.size() == 0)
      $display("PASS epoch_to_utc_calendar_top");
    else
      $display("FAIL epoch_to_utc_calendar_top");
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL epoch_to_utc_calendar_top");
    $finish;
  end

endmodule

// File: sim.f
design/etuc_pkg.sv
design/etuc_ctrl.sv
design/etuc_dp.sv
design/epoch_to_utc_calendar_top.sv
sim/epoch_to_utc_calendar_top_test.sv
